// ----- src/axis_angle_to_rotation_matrix_defines.svh -----
// Assertion helpers shared by the RTL modules.
// Each helper expects signals named clk and rst in the calling scope.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH

// Check a same-cycle implication.
`define AAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aar assertion failed");

// Check an implication in the next cycle.
`define AAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aar assertion failed");

`endif

// ----- src/aar_pkg.sv -----
`default_nettype none
package aar_pkg;

  // Iteration counts
  localparam int SQ_STEPS     = 20;
  localparam int SQ_BIT_TOP   = 2 * SQ_STEPS - 2;
  localparam int DIV_STEPS    = 17;
  localparam int CORDIC_STEPS = 24;
  localparam int WRAP_STEPS   = 3;
  localparam int PRE_STAGES   = WRAP_STEPS + 2;

  // Widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
  localparam int N_OUT = 9;
  localparam int SQ_W  = 31;
  localparam int N_W   = 40;
  localparam int LEN_W = 20;
  localparam int Q_W   = 17;
  localparam int R_W   = 21;
  localparam int U_W   = 18;
  localparam int TH_W  = 37;
  localparam int XY_W  = 34;
  localparam int SC_W  = 18;
  localparam int V_W   = 20;
  localparam int P_W   = 36;
  localparam int E_W   = 58;
  localparam int RES_SHIFT = 34;

  // Constants (angles in Q.30)
  localparam logic signed [TH_W-1:0] Q30_PI      = 37'sh0C90FDAA2;
  localparam logic signed [TH_W-1:0] Q30_HALF_PI = 37'sh06487ED51;
  localparam logic signed [TH_W-1:0] Q30_TWO_PI  = 37'sh1921FB544;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [Q_W-1:0]         UNIT_ONE    = 17'd65536;
  localparam logic signed [OUT_W-1:0] Q14_MAX    = 16'sd16384;
  localparam logic signed [OUT_W-1:0] Q14_MIN    = -16'sd16384;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] ang;
    logic                   mode;
  } item_t;

  typedef struct packed {
    item_t          it;
    logic [N_W-1:0] n;
    logic [N_W-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [LEN_W-1:0]       len;
    logic [2:0]             neg_u;
    logic [2:0][R_W-1:0]    r;
    logic [2:0][Q_W-1:0]    q;
    logic signed [TH_W-1:0] th;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic                   flip;
  } rot_t;

  typedef struct packed {
    logic signed [U_W-1:0]  ux;
    logic signed [U_W-1:0]  uy;
    logic signed [U_W-1:0]  uz;
    logic signed [XY_W-1:0] s30;
    logic signed [XY_W-1:0] c30;
  } trig_t;

  // Arctangent table, Q.30
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] a;
    case (i)
      0:  a = 30'h3243F6A8;
      1:  a = 30'h1DAC6705;
      2:  a = 30'h0FADBAFC;
      3:  a = 30'h07F56EA6;
      4:  a = 30'h03FEAB76;
      5:  a = 30'h01FFD55B;
      6:  a = 30'h00FFFAAA;
      7:  a = 30'h007FFF55;
      8:  a = 30'h003FFFEA;
      9:  a = 30'h001FFFFD;
      10: a = 30'h000FFFFF;
      11: a = 30'h0007FFFF;
      12: a = 30'h0003FFFF;
      13: a = 30'h0001FFFF;
      14: a = 30'h0000FFFF;
      15: a = 30'h00007FFF;
      16: a = 30'h00003FFF;
      17: a = 30'h00001FFF;
      18: a = 30'h00000FFF;
      19: a = 30'h000007FF;
      20: a = 30'h000003FF;
      21: a = 30'h000001FF;
      22: a = 30'h000000FF;
      23: a = 30'h0000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- src/aar_sqrt.sv -----
`default_nettype none
`include "axis_angle_to_rotation_matrix_defines.svh"
module aar_sqrt
  import aar_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire logic             in_valid,
  input  wire item_t            in_item,
  output logic                  out_valid,
  output item_t                 out_item,
  output logic [LEN_W-1:0]      out_len
);

  logic             a_valid;
  item_t            a_item;
  logic [SQ_W-1:0]  sqx, sqy, sqz;
  logic signed [31:0] px, py, pz;
  logic [31:0]      l2;

  logic vld [0:SQ_STEPS];
  sq_t  st  [0:SQ_STEPS];

  // Square the components
  always_comb begin
    px = in_item.ax * in_item.ax;
    py = in_item.ay * in_item.ay;
    pz = in_item.az * in_item.az;
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (ce) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_item <= in_item;
      sqx    <= px[SQ_W-1:0];
      sqy    <= py[SQ_W-1:0];
      sqz    <= pz[SQ_W-1:0];
    end
  end

  // Sum squares, scale into the root's radicand
  always_comb l2 = 32'(sqx) + 32'(sqy) + 32'(sqz);

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ce) vld[0] <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st[0].it  <= a_item;
      st[0].n   <= {l2, 8'b0};
      st[0].res <= '0;
    end
  end

  // One root bit per stage
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [N_W-1:0] BIT = N_W'(1) << (SQ_BIT_TOP - 2 * i);
    logic [N_W:0] trial;
    sq_t          nxt;

    always_comb begin
      trial = {1'b0, st[i].res} + {1'b0, BIT};
      nxt   = st[i];
      if ({1'b0, st[i].n} >= trial) begin
        nxt.n   = st[i].n - trial[N_W-1:0];
        nxt.res = (st[i].res >> 1) + BIT;
      end else begin
        nxt.res = st[i].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (ce) vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      if (ce) st[i+1] <= nxt;
    end
  end

  assign out_valid = vld[SQ_STEPS];
  assign out_item  = st[SQ_STEPS].it;
  assign out_len   = st[SQ_STEPS].res[LEN_W-1:0];

  `AAR_ASSERT_IMP(a_len_fits, vld[SQ_STEPS], st[SQ_STEPS].res[N_W-1:LEN_W] == '0)

endmodule
`default_nettype wire

// ----- src/aar_rotor.sv -----
`default_nettype none
`include "axis_angle_to_rotation_matrix_defines.svh"
module aar_rotor
  import aar_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire logic             in_valid,
  input  wire item_t            in_item,
  input  wire logic [LEN_W-1:0] in_len,
  output logic                  out_valid,
  output trig_t                 out_trig
);

  localparam int LAST = PRE_STAGES - 1 + CORDIC_STEPS;
  localparam int DIV_DONE = PRE_STAGES - 1 + DIV_STEPS;

  logic vld [0:LAST];
  rot_t st  [0:LAST];
  rot_t init;
  logic [IN_W-1:0] mag [3];
  logic signed [IN_W-1:0] comp [3];

  // Select the angle, start the dividers and the rotation
  always_comb begin
    comp[0] = in_item.ax;
    comp[1] = in_item.ay;
    comp[2] = in_item.az;
    init = '0;
    init.len = in_len;
    for (int j = 0; j < 3; j++) begin
      mag[j] = comp[j][IN_W-1] ? IN_W'(-comp[j]) : comp[j];
      init.neg_u[j] = comp[j][IN_W-1];
      init.r[j] = {2'b0, mag[j], 3'b0};
    end
    init.th = in_item.mode ? $signed({3'b0, in_len, 14'b0})
                           : $signed({{3{in_item.ang[IN_W-1]}}, in_item.ang, 18'b0});
    init.x = CORDIC_GAIN;
    init.y = '0;
    init.flip = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ce) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) st[0] <= init;
  end

  // Wrap the angle by whole turns
  for (genvar k = 1; k <= WRAP_STEPS; k++) begin : g_wrap
    rot_t nxt;
    always_comb begin
      nxt = st[k-1];
      if (st[k-1].th > Q30_PI) nxt.th = st[k-1].th - Q30_TWO_PI;
      else if (st[k-1].th < -Q30_PI) nxt.th = st[k-1].th + Q30_TWO_PI;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (ce) vld[k] <= vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (ce) st[k] <= nxt;
    end
  end

  // Fold into the right half plane
  rot_t fold;
  always_comb begin
    fold = st[WRAP_STEPS];
    if (st[WRAP_STEPS].th > Q30_HALF_PI) begin
      fold.th = st[WRAP_STEPS].th - Q30_PI;
      fold.flip = 1'b1;
    end else if (st[WRAP_STEPS].th < -Q30_HALF_PI) begin
      fold.th = st[WRAP_STEPS].th + Q30_PI;
      fold.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[WRAP_STEPS+1] <= 1'b0;
    else if (ce) vld[WRAP_STEPS+1] <= vld[WRAP_STEPS];
  end

  always_ff @(posedge clk) begin
    if (ce) st[WRAP_STEPS+1] <= fold;
  end

  // CORDIC micro-rotations; the first DIV_STEPS of them also take one quotient bit of each divider
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int SRC = PRE_STAGES - 1 + i;
    localparam logic signed [TH_W-1:0] AT = TH_W'(atan_q30(i));
    logic signed [XY_W-1:0] dx, dy;
    logic [R_W-1:0] r2 [3];
    rot_t nxt;

    always_comb begin
      dx  = st[SRC].y >>> i;
      dy  = st[SRC].x >>> i;
      nxt = st[SRC];
      if (st[SRC].th >= 0) begin
        nxt.x  = st[SRC].x - dx;
        nxt.y  = st[SRC].y + dy;
        nxt.th = st[SRC].th - AT;
      end else begin
        nxt.x  = st[SRC].x + dx;
        nxt.y  = st[SRC].y - dy;
        nxt.th = st[SRC].th + AT;
      end
      for (int j = 0; j < 3; j++) begin
        r2[j] = {st[SRC].r[j][R_W-2:0], 1'b0};
        if (i < DIV_STEPS) begin
          if (r2[j] >= {1'b0, st[SRC].len}) begin
            nxt.r[j] = r2[j] - {1'b0, st[SRC].len};
            nxt.q[j] = {st[SRC].q[j][Q_W-2:0], 1'b1};
          end else begin
            nxt.r[j] = r2[j];
            nxt.q[j] = {st[SRC].q[j][Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[SRC+1] <= 1'b0;
      else if (ce) vld[SRC+1] <= vld[SRC];
    end
    always_ff @(posedge clk) begin
      if (ce) st[SRC+1] <= nxt;
    end
  end

  // Saturate the axis, apply signs
  trig_t res;
  logic [Q_W-1:0] qs [3];
  logic signed [U_W-1:0] u [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qs[j] = (st[LAST].q[j] > UNIT_ONE) ? UNIT_ONE : st[LAST].q[j];
      if (st[LAST].len == '0) u[j] = '0;
      else if (st[LAST].neg_u[j]) u[j] = -$signed({1'b0, qs[j]});
      else u[j] = $signed({1'b0, qs[j]});
    end
    res.ux  = u[0];
    res.uy  = u[1];
    res.uz  = u[2];
    res.s30 = st[LAST].flip ? -st[LAST].y : st[LAST].y;
    res.c30 = st[LAST].flip ? -st[LAST].x : st[LAST].x;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= vld[LAST];
  end

  always_ff @(posedge clk) begin
    if (ce) out_trig <= res;
  end

  `AAR_ASSERT_IMP(a_fold_range, vld[WRAP_STEPS+1],
    st[WRAP_STEPS+1].th <= Q30_HALF_PI && st[WRAP_STEPS+1].th >= -Q30_HALF_PI)
  `AAR_ASSERT_IMP(a_div_rem, vld[DIV_DONE] && st[DIV_DONE].len != '0,
    st[DIV_DONE].r[0] < {1'b0, st[DIV_DONE].len} && st[DIV_DONE].r[1] < {1'b0, st[DIV_DONE].len} && st[DIV_DONE].r[2] < {1'b0, st[DIV_DONE].len})

endmodule
`default_nettype wire

// ----- src/aar_matrix.sv -----
`default_nettype none
`include "axis_angle_to_rotation_matrix_defines.svh"
module aar_matrix
  import aar_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   ce,
  input  wire logic                   in_valid,
  input  wire trig_t                  in_trig,
  output logic                        out_valid,
  output logic [N_OUT*OUT_W-1:0]      out_data
);

  localparam logic signed [XY_W:0] ONE_Q30 = (XY_W+1)'(64'sd1 <<< 30);
  localparam logic signed [E_W-1:0] RND = E_W'(64'sd1 <<< (RES_SHIFT - 1));

  // Stage 1: axis products and sine terms
  logic m1_valid;
  logic signed [P_W-1:0]  pp [6];
  logic signed [P_W-1:0]  us [3];
  logic signed [SC_W-1:0] c1;
  logic signed [V_W-1:0]  v1;
  logic signed [XY_W:0]   vd;
  logic signed [XY_W-1:0] s_sh, c_sh;

  always_comb begin
    s_sh = in_trig.s30 >>> 14;
    c_sh = in_trig.c30 >>> 14;
    vd   = ONE_Q30 - {in_trig.c30[XY_W-1], in_trig.c30};
  end

  always_ff @(posedge clk) begin
    if (rst) m1_valid <= 1'b0;
    else if (ce) m1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pp[0] <= in_trig.ux * in_trig.ux;
      pp[1] <= in_trig.uy * in_trig.uy;
      pp[2] <= in_trig.uz * in_trig.uz;
      pp[3] <= in_trig.ux * in_trig.uy;
      pp[4] <= in_trig.ux * in_trig.uz;
      pp[5] <= in_trig.uy * in_trig.uz;
      us[0] <= in_trig.ux * SC_W'(s_sh);
      us[1] <= in_trig.uy * SC_W'(s_sh);
      us[2] <= in_trig.uz * SC_W'(s_sh);
      c1    <= SC_W'(c_sh);
      v1    <= V_W'(vd >>> 14);
    end
  end

  // Stage 2: scale by one minus cosine, align the sine and cosine terms
  logic m2_valid;
  logic signed [E_W-1:0] pv [6];
  logic signed [E_W-1:0] ut [3];
  logic signed [E_W-1:0] ct;

  always_ff @(posedge clk) begin
    if (rst) m2_valid <= 1'b0;
    else if (ce) m2_valid <= m1_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 6; j++) pv[j] <= pp[j] * v1;
      for (int j = 0; j < 3; j++) ut[j] <= E_W'(us[j]) <<< 16;
      ct <= E_W'(c1) <<< 32;
    end
  end

  // Stage 3: combine terms, add the rounding offset
  logic m3_valid;
  logic signed [E_W-1:0] e [N_OUT];

  always_ff @(posedge clk) begin
    if (rst) m3_valid <= 1'b0;
    else if (ce) m3_valid <= m2_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e[0] <= pv[0] + ct    + RND;
      e[1] <= pv[3] + ut[2] + RND;
      e[2] <= pv[4] - ut[1] + RND;
      e[3] <= pv[3] - ut[2] + RND;
      e[4] <= pv[1] + ct    + RND;
      e[5] <= pv[5] + ut[0] + RND;
      e[6] <= pv[4] + ut[1] + RND;
      e[7] <= pv[5] - ut[0] + RND;
      e[8] <= pv[2] + ct    + RND;
    end
  end

  // Stage 4: shift to Q1.14 and saturate
  logic signed [E_W-RES_SHIFT-1:0] rs [N_OUT];
  logic [N_OUT*OUT_W-1:0] sat;

  always_comb begin
    for (int k = 0; k < N_OUT; k++) begin
      rs[k] = (E_W-RES_SHIFT)'(e[k] >>> RES_SHIFT);
      if (rs[k] > (E_W-RES_SHIFT)'(Q14_MAX)) sat[k*OUT_W +: OUT_W] = Q14_MAX;
      else if (rs[k] < (E_W-RES_SHIFT)'(Q14_MIN)) sat[k*OUT_W +: OUT_W] = Q14_MIN;
      else sat[k*OUT_W +: OUT_W] = rs[k][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= m3_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) out_data <= sat;
  end

  `AAR_ASSERT_NEXT(a_diag_range, ce && m3_valid,
    $signed(out_data[OUT_W-1:0]) <= Q14_MAX && $signed(out_data[OUT_W-1:0]) >= Q14_MIN)

endmodule
`default_nettype wire

// ----- src/axis_angle_to_rotation_matrix.sv -----
// Throughput: one transaction per cycle; the square-root, divider and CORDIC chains
// each retire one iteration per pipeline stage.
// The whole pipeline holds while a result waits on the output.
// Reset (rst, synchronous, active high) clears all valid bits and the mode register.
`default_nettype none
module axis_angle_to_rotation_matrix
  import aar_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // axis_x, axis_y, axis_z, rot_angle
  input  wire logic [63:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z
  output logic [143:0]       m_axis_tdata,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata
);

  logic             ce;
  logic             mode;
  item_t            item;
  logic             sq_valid;
  item_t            sq_item;
  logic [LEN_W-1:0] sq_len;
  logic             rot_valid;
  trig_t            rot_trig;

  // Advance the pipeline unless the output is stalled
  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_we) mode <= cfg_wdata;
  end

  always_comb begin
    item.ax   = s_axis_tdata[15:0];
    item.ay   = s_axis_tdata[31:16];
    item.az   = s_axis_tdata[47:32];
    item.ang  = s_axis_tdata[63:48];
    item.mode = mode;
  end

  aar_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_axis_tvalid),
    .in_item   (item),
    .out_valid (sq_valid),
    .out_item  (sq_item),
    .out_len   (sq_len)
  );

  aar_rotor u_rotor (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sq_valid),
    .in_item   (sq_item),
    .in_len    (sq_len),
    .out_valid (rot_valid),
    .out_trig  (rot_trig)
  );

  aar_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (rot_valid),
    .in_trig   (rot_trig),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire
